[rtl/smagvis_pkg.sv]
// ----------------------------------------------------------------------------
// smagvis_pkg
// Shared constants, stage records and datapath step functions for the
// Smagorinsky eddy viscosity pipeline.
// ----------------------------------------------------------------------------
package smagvis_pkg;

  localparam int LAT = 196;

  localparam logic [2:0] REG_SMAG    = 3'd0;
  localparam logic [2:0] REG_TPR     = 3'd1;
  localparam logic [2:0] REG_DX      = 3'd2;
  localparam logic [2:0] REG_DY      = 3'd3;
  localparam logic [2:0] REG_SURFACE = 3'd4;
  localparam logic [2:0] REG_MASON   = 3'd5;

  localparam logic [15:0] SMAG_RST   = 16'd15073;
  localparam logic [19:0] TPR_RST    = 20'd21845;
  localparam logic [31:0] DX_RST     = 32'd65536;
  localparam logic [31:0] DY_RST     = 32'd65536;

  localparam logic [15:0] KAPPA_Q16  = 16'd26214;
  localparam logic [63:0] ONE_Q32    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] RATIO_EPS  = 64'd4;
  localparam logic [63:0] RATIO_CAP  = 64'h0000_0000_FFFF_FFFC;
  localparam logic [63:0] OM_SAT_LIM = 64'hFFFF_FFFE_FFFF_FFFF;
  localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;

  // ratio divide and cube root stages
  typedef struct packed {
    logic        zs;
    logic        neg;
    logic        magz;
    logic        ovf;
    logic [47:0] s2;
    logic [47:0] lw;
    logic [68:0] rem;
    logic [63:0] nlo;
    logic [63:0] q;
    logic [67:0] dv;
    logic [95:0] crem;
    logic [31:0] cr;
    logic [65:0] c3sq;
  } d1_t;

  typedef struct packed {
    logic        zs;
    logic        osat;
    logic [47:0] s2;
    logic [47:0] lw;
    logic [47:0] m0;
    logic [63:0] om;
  } m1_t;

  typedef struct packed {
    logic        zs;
    logic        osat;
    logic [63:0] pm_ll;
    logic [47:0] pm_lh;
    logic [31:0] pm_hh;
    logic [63:0] pl_ll;
    logic [47:0] pl_lh;
    logic [31:0] pl_hh;
    logic [63:0] px_ll;
    logic [47:0] px_lh;
    logic [47:0] px_hl;
    logic [31:0] px_hh;
    logic [63:0] ps_ll;
    logic [63:0] ps_lh;
    logic [47:0] ps_hl;
    logic [47:0] ps_hh;
  } m2_t;

  typedef struct packed {
    logic         zs;
    logic         osat;
    logic [95:0]  m0sq;
    logic [95:0]  lwsq;
    logic [95:0]  nml;
    logic [111:0] so;
  } m3_t;

  // twin square root stages
  typedef struct packed {
    logic         zs;
    logic         osat;
    logic [95:0]  nml;
    logic [63:0]  msqn;
    logic [111:0] xa;
    logic [111:0] xb;
    logic [55:0]  ra;
    logic [57:0]  rema;
    logic [55:0]  rb;
    logic [57:0]  remb;
  } sq_t;

  // wall length divide stages
  typedef struct packed {
    logic        zs;
    logic        osat;
    logic        den0;
    logic [55:0] g;
    logic [63:0] msqn;
    logic [68:0] rem;
    logic [63:0] nlo;
    logic [63:0] q;
    logic [67:0] dv;
  } dd_t;

  typedef struct packed {
    logic        zs;
    logic        osat;
    logic [55:0] g;
    logic [63:0] msqn;
    logic [63:0] e_ll;
    logic [47:0] e_lh;
    logic [31:0] e_hh;
  } e1_t;

  typedef struct packed {
    logic        zs;
    logic        osat;
    logic [55:0] g;
    logic [63:0] msq;
  } e2_t;

  typedef struct packed {
    logic        zs;
    logic        osat;
    logic [63:0] ll;
    logic [55:0] lh;
    logic [63:0] hl;
    logic [55:0] hh;
  } e3_t;

  // one restoring divide step: {quotient bit, new remainder}
  function automatic logic [69:0] div_step(logic [68:0] rem, logic nb, logic [67:0] dv);
    logic [69:0] sh;
    logic [69:0] df;
    sh = {rem, nb};
    df = sh - {2'b00, dv};
    if (!df[69]) begin
      return {1'b1, df[68:0]};
    end else begin
      return {1'b0, sh[68:0]};
    end
  endfunction

  // one digit of integer square root: {new root, new remainder}
  function automatic logic [113:0] sqrt_step(logic [57:0] rem, logic [1:0] xb,
                                             logic [55:0] root);
    logic [59:0] sh;
    logic [59:0] tr;
    logic [59:0] df;
    sh = {rem, xb};
    tr = {2'b00, root, 2'b01};
    df = sh - tr;
    if (!df[59]) begin
      return {root[54:0], 1'b1, df[57:0]};
    end else begin
      return {root[54:0], 1'b0, sh[57:0]};
    end
  endfunction

endpackage

[rtl/smagorinsky_viscosity_stability_top.sv]
// ----------------------------------------------------------------------------
// smagorinsky_viscosity_stability_top
// Eddy viscosity of one grid cell per clock: Smagorinsky mixing length with
// optional Mason wall damping and a stability correction.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low; busy is high
//   only while rst_n is asserted. One cell may enter every clock.
//   Each transaction yields exactly one result, shown for one cycle with
//   out_strobe high; results leave in order.
//   The receiver has no backpressure.
//   The pipeline is made of the 64-step ratio divider (which hosts the
//   32-step cube root), the 56-step twin square root and the 64-step wall
//   length divider, one quotient or root digit per stage, plus twelve
//   stages of capture, split multipliers, adders and the output register.
//   Throughput: one cell per cycle.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while no
//   transaction is in flight. Reset restores register defaults and drops
//   every transaction in flight.
// ----------------------------------------------------------------------------
module smagorinsky_viscosity_stability_top import smagvis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] in_strain_sq,
  input  logic [47:0] in_buoyancy_gradient,
  input  logic [31:0] in_height,
  input  logic [31:0] in_layer_thickness,
  input  logic [31:0] in_roughness,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_strobe,
  output logic [47:0] out_eddy_viscosity,
  output logic        out_saturated
);

  logic [15:0] cs_r;
  logic [19:0] tpr_r;
  logic [31:0] cx_r;
  logic [31:0] cy_r;
  logic        surf_r;
  logic        mason_r;
  logic [63:0] dxy_r;
  logic        mason_on;

  logic [LAT-1:0] vld_r;
  logic           accept;

  logic [47:0] a_s2_r;
  logic [47:0] a_mag_r;
  logic        a_neg_r;
  logic        a_zs_r;
  logic [32:0] a_zsum_r;
  logic [31:0] a_dz_r;

  logic [63:0] b_vlo_r;
  logic [63:0] b_vhi_r;
  logic [51:0] b_dlo_r;
  logic [35:0] b_dhi_r;
  logic [47:0] b_lw_r;
  logic [47:0] b_s2_r;
  logic [47:0] b_mag_r;
  logic        b_neg_r;
  logic        b_zs_r;

  d1_t st_r [0:64];
  d1_t c_nxt;
  logic [67:0] c_d;

  m1_t m1_r;
  m1_t m1_nxt;
  logic [63:0] qe;
  m2_t m2_r;
  m3_t m3_r;

  sq_t sq_r [0:56];
  dd_t dd_r [0:64];

  e1_t e1_r;
  logic [47:0] mlen;
  e2_t e2_r;
  logic [95:0] mlsq;
  e3_t e3_r;
  logic [119:0] prod;
  logic [87:0]  res;

  logic [47:0] out_ev_r;
  logic        out_sat_r;

  assign busy     = ~rst_n;
  assign accept   = start & ~busy;
  assign mason_on = surf_r & mason_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r    <= SMAG_RST;
      tpr_r   <= TPR_RST;
      cx_r    <= DX_RST;
      cy_r    <= DY_RST;
      surf_r  <= 1'b0;
      mason_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMAG:    cs_r    <= cfg_wdata[15:0];
        REG_TPR:     tpr_r   <= cfg_wdata[19:0];
        REG_DX:      cx_r    <= cfg_wdata;
        REG_DY:      cy_r    <= cfg_wdata;
        REG_SURFACE: surf_r  <= cfg_wdata[0];
        REG_MASON:   mason_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dxy_r <= 64'(cx_r) * 64'(cy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // stage A: capture
  always_ff @(posedge clk) begin
    a_s2_r   <= in_strain_sq;
    a_mag_r  <= in_buoyancy_gradient[47] ? (48'd0 - in_buoyancy_gradient)
                                         : in_buoyancy_gradient;
    a_neg_r  <= in_buoyancy_gradient[47];
    a_zs_r   <= (in_strain_sq == 48'd0);
    a_zsum_r <= {1'b0, in_height} + {1'b0, in_roughness};
    a_dz_r   <= in_layer_thickness;
  end

  // stage B: cell volume, ratio divisor and wall length products
  always_ff @(posedge clk) begin
    b_vlo_r <= 64'(dxy_r[31:0]) * 64'(a_dz_r);
    b_vhi_r <= 64'(dxy_r[63:32]) * 64'(a_dz_r);
    b_dlo_r <= 52'(a_s2_r[31:0]) * 52'(tpr_r);
    b_dhi_r <= 36'(a_s2_r[47:32]) * 36'(tpr_r);
    b_lw_r  <= 48'(a_zsum_r) * 48'(KAPPA_Q16);
    b_s2_r  <= a_s2_r;
    b_mag_r <= a_mag_r;
    b_neg_r <= a_neg_r;
    b_zs_r  <= a_zs_r;
  end

  // stage C: sums, divider setup
  always_comb begin
    c_d        = {16'd0, b_dlo_r} + {b_dhi_r, 32'd0};
    c_nxt      = '0;
    c_nxt.zs   = b_zs_r;
    c_nxt.neg  = b_neg_r;
    c_nxt.magz = (b_mag_r == 48'd0);
    c_nxt.ovf  = (c_d == 68'd0) || ({36'd0, b_mag_r[47:16]} >= c_d);
    c_nxt.s2   = b_s2_r;
    c_nxt.lw   = b_lw_r;
    c_nxt.rem  = {37'd0, b_mag_r[47:16]};
    c_nxt.nlo  = {b_mag_r[15:0], 48'd0};
    c_nxt.dv   = c_d;
    c_nxt.crem = {32'd0, b_vlo_r} + {b_vhi_r, 32'd0};
  end

  always_ff @(posedge clk) begin
    st_r[0] <= c_nxt;
  end

  // ratio divide, cube root in the first 32 stages
  for (genvar k = 0; k < 64; k++) begin : g_d1
    localparam bit CBRT_ON = (k < 32);
    localparam int B       = (k < 32) ? 31 - k : 0;
    d1_t         d1_nxt;
    logic [69:0] ds;
    logic [33:0] cr3;
    logic [99:0] inc;
    logic [65:0] t2;

    always_comb begin
      d1_nxt     = st_r[k];
      ds         = div_step(st_r[k].rem, st_r[k].nlo[63], st_r[k].dv);
      d1_nxt.rem = ds[68:0];
      d1_nxt.q   = {st_r[k].q[62:0], ds[69]};
      d1_nxt.nlo = {st_r[k].nlo[62:0], 1'b0};
      cr3 = {2'b00, st_r[k].cr} + {1'b0, st_r[k].cr, 1'b0};
      inc = ({34'd0, st_r[k].c3sq} << B) + ({66'd0, cr3} << (2 * B)) + (100'd1 << (3 * B));
      t2  = ({34'd0, st_r[k].cr} << (B + 1)) + (66'd1 << (2 * B));
      if (CBRT_ON && ({4'd0, st_r[k].crem} >= inc)) begin
        d1_nxt.crem = st_r[k].crem - inc[95:0];
        d1_nxt.cr   = st_r[k].cr | (32'd1 << B);
        d1_nxt.c3sq = st_r[k].c3sq + t2 + {t2[64:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      st_r[k+1] <= d1_nxt;
    end
  end

  // M1: base length, 1 - ratio
  always_comb begin
    qe = st_r[64].magz ? 64'd0 : (st_r[64].ovf ? '1 : st_r[64].q);
    m1_nxt      = '0;
    m1_nxt.zs   = st_r[64].zs;
    m1_nxt.s2   = st_r[64].s2;
    m1_nxt.lw   = st_r[64].lw;
    m1_nxt.m0   = 48'(cs_r) * 48'(st_r[64].cr);
    if (!st_r[64].neg) begin
      m1_nxt.om = (qe >= RATIO_CAP) ? RATIO_EPS : (ONE_Q32 - qe);
    end else if (qe > OM_SAT_LIM) begin
      m1_nxt.om   = '1;
      m1_nxt.osat = 1'b1;
    end else begin
      m1_nxt.om = ONE_Q32 + qe;
    end
  end

  always_ff @(posedge clk) begin
    m1_r <= m1_nxt;
  end

  // M2: partial products
  always_ff @(posedge clk) begin
    m2_r.zs    <= m1_r.zs;
    m2_r.osat  <= m1_r.osat;
    m2_r.pm_ll <= 64'(m1_r.m0[31:0]) * 64'(m1_r.m0[31:0]);
    m2_r.pm_lh <= 48'(m1_r.m0[31:0]) * 48'(m1_r.m0[47:32]);
    m2_r.pm_hh <= 32'(m1_r.m0[47:32]) * 32'(m1_r.m0[47:32]);
    m2_r.pl_ll <= 64'(m1_r.lw[31:0]) * 64'(m1_r.lw[31:0]);
    m2_r.pl_lh <= 48'(m1_r.lw[31:0]) * 48'(m1_r.lw[47:32]);
    m2_r.pl_hh <= 32'(m1_r.lw[47:32]) * 32'(m1_r.lw[47:32]);
    m2_r.px_ll <= 64'(m1_r.m0[31:0]) * 64'(m1_r.lw[31:0]);
    m2_r.px_lh <= 48'(m1_r.m0[31:0]) * 48'(m1_r.lw[47:32]);
    m2_r.px_hl <= 48'(m1_r.m0[47:32]) * 48'(m1_r.lw[31:0]);
    m2_r.px_hh <= 32'(m1_r.m0[47:32]) * 32'(m1_r.lw[47:32]);
    m2_r.ps_ll <= 64'(m1_r.s2[31:0]) * 64'(m1_r.om[31:0]);
    m2_r.ps_lh <= 64'(m1_r.s2[31:0]) * 64'(m1_r.om[63:32]);
    m2_r.ps_hl <= 48'(m1_r.s2[47:32]) * 48'(m1_r.om[31:0]);
    m2_r.ps_hh <= 48'(m1_r.s2[47:32]) * 48'(m1_r.om[63:32]);
  end

  // M3: product sums
  always_ff @(posedge clk) begin
    m3_r.zs   <= m2_r.zs;
    m3_r.osat <= m2_r.osat;
    m3_r.m0sq <= {32'd0, m2_r.pm_ll} + {15'd0, m2_r.pm_lh, 33'd0} + {m2_r.pm_hh, 64'd0};
    m3_r.lwsq <= {32'd0, m2_r.pl_ll} + {15'd0, m2_r.pl_lh, 33'd0} + {m2_r.pl_hh, 64'd0};
    m3_r.nml  <= {32'd0, m2_r.px_ll} + {16'd0, m2_r.px_lh, 32'd0}
               + {16'd0, m2_r.px_hl, 32'd0} + {m2_r.px_hh, 64'd0};
    m3_r.so   <= {48'd0, m2_r.ps_ll} + {16'd0, m2_r.ps_lh, 32'd0}
               + {32'd0, m2_r.ps_hl, 32'd0} + {m2_r.ps_hh, 64'd0};
  end

  // square root setup
  always_ff @(posedge clk) begin
    sq_r[0].zs   <= m3_r.zs;
    sq_r[0].osat <= m3_r.osat;
    sq_r[0].nml  <= m3_r.nml;
    sq_r[0].msqn <= m3_r.m0sq[95:32];
    sq_r[0].xa   <= {15'd0, {1'b0, m3_r.m0sq} + {1'b0, m3_r.lwsq}};
    sq_r[0].xb   <= m3_r.so;
    sq_r[0].ra   <= '0;
    sq_r[0].rema <= '0;
    sq_r[0].rb   <= '0;
    sq_r[0].remb <= '0;
  end

  // Mason denominator and stability root side by side
  for (genvar j = 0; j < 56; j++) begin : g_sq
    sq_t          sq_nxt;
    logic [113:0] sa;
    logic [113:0] sb;

    always_comb begin
      sq_nxt      = sq_r[j];
      sa          = sqrt_step(sq_r[j].rema, sq_r[j].xa[111:110], sq_r[j].ra);
      sb          = sqrt_step(sq_r[j].remb, sq_r[j].xb[111:110], sq_r[j].rb);
      sq_nxt.ra   = sa[113:58];
      sq_nxt.rema = sa[57:0];
      sq_nxt.rb   = sb[113:58];
      sq_nxt.remb = sb[57:0];
      sq_nxt.xa   = {sq_r[j].xa[109:0], 2'b00};
      sq_nxt.xb   = {sq_r[j].xb[109:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      sq_r[j+1] <= sq_nxt;
    end
  end

  // wall length divide setup
  always_ff @(posedge clk) begin
    dd_r[0].zs   <= sq_r[56].zs;
    dd_r[0].osat <= sq_r[56].osat;
    dd_r[0].den0 <= (sq_r[56].ra == 56'd0);
    dd_r[0].g    <= sq_r[56].rb;
    dd_r[0].msqn <= sq_r[56].msqn;
    dd_r[0].rem  <= {37'd0, sq_r[56].nml[95:64]};
    dd_r[0].nlo  <= sq_r[56].nml[63:0];
    dd_r[0].q    <= '0;
    dd_r[0].dv   <= {12'd0, sq_r[56].ra};
  end

  for (genvar k = 0; k < 64; k++) begin : g_dd
    dd_t         dd_nxt;
    logic [69:0] ds;

    always_comb begin
      dd_nxt     = dd_r[k];
      ds         = div_step(dd_r[k].rem, dd_r[k].nlo[63], dd_r[k].dv);
      dd_nxt.rem = ds[68:0];
      dd_nxt.q   = {dd_r[k].q[62:0], ds[69]};
      dd_nxt.nlo = {dd_r[k].nlo[62:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      dd_r[k+1] <= dd_nxt;
    end
  end

  // E1: damped length squared, partial products
  assign mlen = dd_r[64].den0 ? 48'd0 : dd_r[64].q[47:0];

  always_ff @(posedge clk) begin
    e1_r.zs   <= dd_r[64].zs;
    e1_r.osat <= dd_r[64].osat;
    e1_r.g    <= dd_r[64].g;
    e1_r.msqn <= dd_r[64].msqn;
    e1_r.e_ll <= 64'(mlen[31:0]) * 64'(mlen[31:0]);
    e1_r.e_lh <= 48'(mlen[31:0]) * 48'(mlen[47:32]);
    e1_r.e_hh <= 32'(mlen[47:32]) * 32'(mlen[47:32]);
  end

  // E2: length squared select
  assign mlsq = {32'd0, e1_r.e_ll} + {15'd0, e1_r.e_lh, 33'd0} + {e1_r.e_hh, 64'd0};

  always_ff @(posedge clk) begin
    e2_r.zs   <= e1_r.zs;
    e2_r.osat <= e1_r.osat;
    e2_r.g    <= e1_r.g;
    e2_r.msq  <= mason_on ? mlsq[95:32] : e1_r.msqn;
  end

  // E3: final partial products
  always_ff @(posedge clk) begin
    e3_r.zs   <= e2_r.zs;
    e3_r.osat <= e2_r.osat;
    e3_r.ll   <= 64'(e2_r.msq[31:0]) * 64'(e2_r.g[31:0]);
    e3_r.lh   <= 56'(e2_r.msq[31:0]) * 56'(e2_r.g[55:32]);
    e3_r.hl   <= 64'(e2_r.msq[63:32]) * 64'(e2_r.g[31:0]);
    e3_r.hh   <= 56'(e2_r.msq[63:32]) * 56'(e2_r.g[55:32]);
  end

  // E4: sum, saturate, output register
  assign prod = {56'd0, e3_r.ll} + {32'd0, e3_r.lh, 32'd0}
              + {24'd0, e3_r.hl, 32'd0} + {e3_r.hh, 64'd0};
  assign res  = prod[119:32];

  always_ff @(posedge clk) begin
    priority if (e3_r.zs) begin
      out_ev_r  <= 48'd0;
      out_sat_r <= 1'b0;
    end else if (res[87:48] != 40'd0) begin
      out_ev_r  <= MAX48;
      out_sat_r <= 1'b1;
    end else begin
      out_ev_r  <= res[47:0];
      out_sat_r <= e3_r.osat;
    end
  end

  assign out_strobe         = vld_r[LAT-1];
  assign out_eddy_viscosity = out_ev_r;
  assign out_saturated      = out_sat_r;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Smagorinsky eddy viscosity pipeline. A queue-fed
// driver issues cells in bursts and a monitor checks every result against a
// bit-exact in-bench predictor, over several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import smagvis_pkg::*;

  typedef struct {
    logic [47:0] s2;
    logic [47:0] bg;
    logic [31:0] z;
    logic [31:0] dz;
    logic [31:0] z0;
  } cell_t;

  typedef struct {
    logic [47:0] visc;
    logic        sat;
  } visc_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [47:0] in_strain_sq;
  logic [47:0] in_buoyancy_gradient;
  logic [31:0] in_height;
  logic [31:0] in_layer_thickness;
  logic [31:0] in_roughness;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        out_strobe;
  logic [47:0] out_eddy_viscosity;
  logic        out_saturated;

  cell_t pending_cells[$];
  visc_t expected_visc[$];

  logic [15:0] cs_q;
  logic [19:0] tpr_q;
  logic [31:0] dx_q;
  logic [31:0] dy_q;
  logic        surf_q;
  logic        mason_q;

  int errors;
  int n_cells;
  int n_results;
  int n_sat;

  smagorinsky_viscosity_stability_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_strain_sq         (in_strain_sq),
    .in_buoyancy_gradient (in_buoyancy_gradient),
    .in_height            (in_height),
    .in_layer_thickness   (in_layer_thickness),
    .in_roughness         (in_roughness),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_strobe           (out_strobe),
    .out_eddy_viscosity   (out_eddy_viscosity),
    .out_saturated        (out_saturated)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] int_sqrt(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] int_cbrt(logic [127:0] x);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if ({96'd0, t} * {96'd0, t} * {96'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_div(logic [127:0] n, logic [127:0] d);
    logic [127:0] q;
    q = n / d;
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic visc_t predict_viscosity(cell_t c);
    visc_t        o;
    logic [127:0] m0;
    logic [127:0] lw;
    logic [127:0] den;
    logic [127:0] mlen;
    logic [127:0] wide;
    logic [63:0]  msq;
    logic [127:0] dd;
    logic [47:0]  mag;
    logic [63:0]  q;
    logic [63:0]  om;
    logic [63:0]  g;
    o.visc = '0;
    o.sat = 1'b0;
    if (c.s2 == 0) return o;
    m0 = {112'd0, cs_q} *
         int_cbrt({96'd0, dx_q} * {96'd0, dy_q} * {96'd0, c.dz});
    if (surf_q && mason_q) begin
      lw = ({96'd0, c.z} + {96'd0, c.z0}) * {112'd0, KAPPA_Q16};
      den = {64'd0, int_sqrt(m0 * m0 + lw * lw)};
      mlen = (den != 0) ? {64'd0, sat_div(m0 * lw, den)} : '0;
      wide = (mlen * mlen) >> 32;
    end else begin
      wide = (m0 * m0) >> 32;
    end
    msq = (wide[127:64] != 0) ? '1 : wide[63:0];
    mag = c.bg[47] ? -c.bg : c.bg;
    dd = {80'd0, c.s2} * {108'd0, tpr_q};
    if (mag == 0) q = '0;
    else if (dd == 0) q = '1;
    else q = sat_div({80'd0, mag} << 48, dd);
    if (!c.bg[47]) begin
      om = (q >= ONE_Q32 - RATIO_EPS) ? RATIO_EPS : ONE_Q32 - q;
    end else if (q > 64'hFFFF_FFFF_FFFF_FFFF - ONE_Q32) begin
      om = '1;
      o.sat = 1'b1;
    end else begin
      om = ONE_Q32 + q;
    end
    g = int_sqrt({80'd0, c.s2} * {64'd0, om});
    wide = ({64'd0, msq} * {64'd0, g}) >> 32;
    if (wide > {80'd0, MAX48}) begin
      o.visc = MAX48;
      o.sat = 1'b1;
    end else begin
      o.visc = wide[47:0];
    end
    return o;
  endfunction

  // driver: bursts of cells separated by random gaps
  always @(posedge clk) begin : driver
    logic  go;
    cell_t nxt;
    int    burst_left;
    int    gap_left;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        expected_visc.push_back(predict_viscosity(nxt));
        n_cells++;
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cells.size() > 0) begin
          nxt = pending_cells.pop_front();
          in_strain_sq <= nxt.s2;
          in_buoyancy_gradient <= nxt.bg;
          in_height <= nxt.z;
          in_layer_thickness <= nxt.dz;
          in_roughness <= nxt.z0;
          go = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      start <= go;
    end
  end

  always @(posedge clk) begin : monitor
    visc_t e;
    if (rst_n && out_strobe) begin
      if (expected_visc.size() == 0) begin
        $error("unexpected transaction: eddy_viscosity %h", out_eddy_viscosity);
        errors++;
      end else begin
        e = expected_visc.pop_front();
        n_results++;
        if (e.sat) n_sat++;
        if (out_eddy_viscosity !== e.visc) begin
          $error("eddy_viscosity: expected %h, got %h", e.visc, out_eddy_viscosity);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %b, got %b", e.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SMAG:    cs_q = val[15:0];
      REG_TPR:     tpr_q = val[19:0];
      REG_DX:      dx_q = val;
      REG_DY:      dy_q = val;
      REG_SURFACE: surf_q = val[0];
      REG_MASON:   mason_q = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_scaled();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.s2 = 48'(rand_scaled());
    c.bg = 48'(rand_scaled());
    // mostly stable or mildly unstable ratios, sometimes raw noise
    if ($urandom_range(0, 3) != 0) c.bg = c.s2 >> $urandom_range(0, 24);
    if ($urandom_range(0, 1) == 1) c.bg = -c.bg;
    if ($urandom_range(0, 7) == 0) c.bg = 48'({$urandom, $urandom});
    if ($urandom_range(0, 15) == 0) c.s2 = 48'({$urandom, $urandom});
    c.z = 32'(rand_scaled());
    c.dz = 32'(rand_scaled());
    if (c.dz == 0) c.dz = 32'd1;
    c.z0 = 32'(rand_scaled());
    return c;
  endfunction

  function automatic cell_t mk(logic [47:0] s2, logic [47:0] bg, logic [31:0] z,
                               logic [31:0] dz, logic [31:0] z0);
    cell_t c;
    c.s2 = s2;
    c.bg = bg;
    c.z = z;
    c.dz = dz;
    c.z0 = z0;
    return c;
  endfunction

  task automatic load_directed();
    pending_cells.push_back(mk(48'd0, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0));
    pending_cells.push_back(mk(MAX48, 48'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cells.push_back(mk(48'd1, 48'h7FFF_FFFF_FFFF, 32'd65536, 32'd65536, 32'd0));
    pending_cells.push_back(mk(48'd1, 48'h8000_0000_0000, 32'd65536, 32'd65536, 32'd655));
    pending_cells.push_back(mk(MAX48, 48'h8000_0000_0000, 32'd0, 32'd1, 32'd0));
    pending_cells.push_back(mk(48'h1_0000_0000, MAX48, 32'd6553600, 32'd65536, 32'd6553));
    pending_cells.push_back(mk(48'h1_0000_0000, 48'h1_0000_0000, 32'd0, 32'd65536, 32'd0));
    pending_cells.push_back(mk(MAX48, MAX48, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cells.push_back(mk(MAX48, 48'hFFFF_0000_0000, 32'd0, 32'hFFFF_FFFF, 32'd0));
    pending_cells.push_back(mk(48'h0_0100_0000, 48'h0_0000_0001, 32'd1, 32'd1, 32'd1));
    pending_cells.push_back(mk(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    pending_cells.push_back(mk(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                               32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
  endtask

  task automatic run_phase(int n);
    load_directed();
    repeat (n) pending_cells.push_back(rand_cell());
    while (pending_cells.size() > 0 || start || expected_visc.size() > 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] cs, logic [31:0] tpr, logic [31:0] dx,
                         logic [31:0] dy, logic surf, logic mason);
    write_reg(REG_SMAG, cs);
    write_reg(REG_TPR, tpr);
    write_reg(REG_DX, dx);
    write_reg(REG_DY, dy);
    write_reg(REG_SURFACE, {31'd0, surf});
    write_reg(REG_MASON, {31'd0, mason});
  endtask

  initial begin
    errors = 0;
    n_cells = 0;
    n_results = 0;
    n_sat = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_strain_sq = '0;
    in_buoyancy_gradient = '0;
    in_height = '0;
    in_layer_thickness = 32'd1;
    in_roughness = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SMAG;
    cfg_wdata = '0;
    cs_q = SMAG_RST;
    tpr_q = TPR_RST;
    dx_q = DX_RST;
    dy_q = DY_RST;
    surf_q = 1'b0;
    mason_q = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_phase(150);
    set_all(32'd65535, 32'd1, 32'd1, 32'd1, 1'b1, 1'b1);
    run_phase(150);
    set_all(32'd0, 32'hF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    run_phase(150);
    set_all(32'd15073, 32'd21845, 32'd3276800, 32'd3276800, 1'b1, 1'b1);
    run_phase(150);
    set_all($urandom, $urandom_range(1, 20'hF_FFFF), $urandom_range(1, 32'hFFFF_FFFF),
            $urandom_range(1, 32'hFFFF_FFFF), 1'b1, 1'b1);
    run_phase(150);
    set_all(32'd65535, 32'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    run_phase(150);
    set_all($urandom, $urandom_range(1, 20'hF_FFFF), $urandom_range(1, 32'd655360),
            $urandom_range(1, 32'd655360), 1'b1, 1'b1);
    run_phase(150);
    set_all(32'(SMAG_RST), 32'(TPR_RST), DX_RST, DY_RST, 1'b0, 1'b0);
    run_phase(150);
    $display("tb_top: %0d cells over 8 register settings, %0d results, %0d saturated",
             n_cells, n_results, n_sat);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
